@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the list reorder block, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ars_pkg.sv @@
// ----------------------------------------------------------------------------
// ars_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_ASC;

  typedef struct packed {
    logic load;
    logic outer_rd;
    logic outer_cap;
    logic inner_step;
    logic outer_wb;
    logic out_step;
  } cmd_t;

  typedef struct packed {
    logic sort_mode;
    logic short_list;
    logic inner_end;
    logic outer_end;
    logic out_end;
  } sts_t;

endpackage

@@ hdl/ars_ctrl.sv @@
// ----------------------------------------------------------------------------
// ars_ctrl
// sequencer for load, exchange sort passes and list output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ars_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last,
  input  ars_pkg::sts_t sts,
  output logic          busy,
  output ars_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OLOAD = 3'd1;
  localparam logic [2:0] S_OCAP  = 3'd2;
  localparam logic [2:0] S_ICMP  = 3'd3;
  localparam logic [2:0] S_OWB   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = sts.sort_mode ? S_OLOAD : S_OUT;
          end
        end
      end
      S_OLOAD: begin
        cmd.outer_rd = 1'b1;
        state_nxt    = sts.short_list ? S_OUT : S_OCAP;
      end
      S_OCAP: begin
        cmd.outer_cap = 1'b1;
        state_nxt     = S_ICMP;
      end
      S_ICMP: begin
        cmd.inner_step = 1'b1;
        if (sts.inner_end) begin
          state_nxt = S_OWB;
        end
      end
      S_OWB: begin
        cmd.outer_wb = 1'b1;
        state_nxt    = sts.outer_end ? S_OUT : S_OCAP;
      end
      S_OUT: begin
        cmd.out_step = 1'b1;
        if (sts.out_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPLY(a_icmp_entry, state_r == S_ICMP, $past(state_r) == S_OCAP || $past(state_r) == S_ICMP, "compare step entered out of order")
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")

endmodule

@@ hdl/ars_datapath.sv @@
// ----------------------------------------------------------------------------
// ars_datapath
// element store, sort indices, compare-swap unit and output registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ars_datapath #(
  parameter int unsigned DEPTH = ars_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ars_pkg::cmd_t                     cmd,
  output ars_pkg::sts_t                     sts,
  input  logic signed [ars_pkg::DATA_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [ars_pkg::MODE_W-1:0]        cfg_data,
  output logic                              out_strobe,
  output logic signed [ars_pkg::DATA_W-1:0] out_value_res,
  output logic                              out_last_res
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic signed [ars_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic signed [ars_pkg::DATA_W-1:0] rd_r;
  logic signed [ars_pkg::DATA_W-1:0] x_r;
  logic signed [ars_pkg::DATA_W-1:0] x_nxt;

  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 i_r, i_nxt;
  logic [AW-1:0]                 j_r, j_nxt;
  logic [AW-1:0]                 k_r, k_nxt;
  logic [ars_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  logic                          strobe_r, strobe_nxt;
  logic                          last_r, last_nxt;

  logic                          rev;
  logic                          desc;
  logic                          swap;
  logic                          inner_end;
  logic                          outer_end;
  logic                          out_end;
  logic [AW-1:0]                 i_inc, j_inc, k_inc;
  logic [CW-1:0]                 rev_pos;
  logic [AW-1:0]                 rd_addr;
  logic                          we;
  logic [AW-1:0]                 wa;
  logic signed [ars_pkg::DATA_W-1:0] wd;

  always_comb begin
    rev       = (mode_r == ars_pkg::MODE_REVERSE);
    desc      = (mode_r == ars_pkg::MODE_DESC);
    swap      = desc ? (x_r < rd_r) : (rd_r < x_r);
    i_inc     = i_r + AW'(1);
    j_inc     = j_r + AW'(1);
    k_inc     = k_r + AW'(1);
    inner_end = ((CW'(j_r) + CW'(1)) == count_r);
    outer_end = (((CW+1)'(i_r) + (CW+1)'(2)) >= {1'b0, count_r});
    out_end   = ((CW'(k_r) + CW'(1)) == count_r);
    rev_pos   = count_r - CW'(1) - CW'(k_r);

    sts.sort_mode  = (mode_r == ars_pkg::MODE_ASC) || (mode_r == ars_pkg::MODE_DESC);
    sts.short_list = (count_r < CW'(2));
    sts.inner_end  = inner_end;
    sts.outer_end  = outer_end;
    sts.out_end    = out_end;

    rd_addr = '0;
    if (cmd.outer_rd) begin
      rd_addr = i_r;
    end else if (cmd.outer_cap || cmd.outer_wb) begin
      rd_addr = i_inc;
    end else if (cmd.inner_step) begin
      rd_addr = j_inc;
    end else if (cmd.out_step) begin
      rd_addr = rev ? rev_pos[AW-1:0] : k_r;
    end

    we = 1'b0;
    wa = i_r;
    wd = x_r;
    if (cmd.load && (count_r < DEPTH_C)) begin
      we = 1'b1;
      wa = count_r[AW-1:0];
      wd = in_value;
    end else if (cmd.inner_step && swap) begin
      we = 1'b1;
      wa = j_r;
    end else if (cmd.outer_wb) begin
      we = 1'b1;
    end

    count_nxt  = count_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    x_nxt      = x_r;
    mode_nxt   = cfg_we ? cfg_data : mode_r;
    strobe_nxt = cmd.out_step;
    last_nxt   = cmd.out_step && out_end;

    if (cmd.load && (count_r < DEPTH_C)) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.outer_cap) begin
      x_nxt = rd_r;
      j_nxt = i_inc;
    end
    if (cmd.inner_step) begin
      j_nxt = j_inc;
      if (swap) begin
        x_nxt = rd_r;
      end
    end
    if (cmd.outer_wb) begin
      i_nxt = outer_end ? '0 : i_inc;
    end
    if (cmd.out_step) begin
      k_nxt = out_end ? '0 : k_inc;
      if (out_end) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      mode_r   <= ars_pkg::MODE_RESET;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      mode_r   <= mode_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_r <= mem_r[rd_addr];
  end

  assign out_strobe    = strobe_r;
  assign out_value_res = rd_r;
  assign out_last_res  = last_r;

  `ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C, "element count beyond store depth")
  `ASSERT_IMPLY(a_inner_above_outer, cmd.inner_step, j_r > i_r, "inner index not above outer index")
  `ASSERT_IMPLY(a_last_clears_count, strobe_r && last_r, count_r == '0, "count not cleared after list output")

endmodule

@@ hdl/array_reverse_and_exchange_sort_top.sv @@
// ----------------------------------------------------------------------------
// array_reverse_and_exchange_sort_top
// list reorder block: load, reverse or exchange sort, then emit the list
// ----------------------------------------------------------------------------
// Items are taken on start, one per cycle while busy is low; extra items past
// DEPTH are dropped, and the item with in_last closes the list. In reverse mode
// and the unused mode the list is read straight out of the store, forward or
// backward, with each element's strobe in the cycle after its read. In the sort
// modes a store with one read and one write port and one compare-swap unit
// sorts the list before it is read out, with the running extreme of each outer
// pass held in a register. out_strobe cannot be stalled: each element is valid
// for exactly one cycle and must be taken then. order_mode is written through
// cfg_* only while busy is low.
module array_reverse_and_exchange_sort_top #(
  parameter int unsigned DEPTH = ars_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ars_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_strobe,
  output logic signed [ars_pkg::DATA_W-1:0] out_value_res,
  output logic                              out_last_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ars_pkg::MODE_W-1:0]        cfg_data
);

  ars_pkg::cmd_t cmd;
  ars_pkg::sts_t sts;
  logic          cfg_we;

  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  ars_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  ars_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_strobe    (out_strobe),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res)
  );

endmodule
